// ===== hw/rtl/tsi_pkg.sv =====
// ---------------------------------------------------------------------------
// tsi_pkg
// Shared types, constants and helpers of the timestamped sample interpolator.
// ---------------------------------------------------------------------------
package tsi_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int NUM_CH = 4;
  localparam int CH_W   = 2;
  localparam int TIME_W = 63;
  localparam int VAL_W  = 32;
  localparam int W_W    = 16;
  localparam int CFG_W  = 32;
  localparam int MASK_W = 4;
  localparam int CFG_IDX_W = 2;

  // Angle wrap: two pi and the floor of pi in Q16.16.
  localparam int TWO_PI    = 411775;
  localparam int PI_FLOOR  = 205887;
  localparam int MOD_W     = 35;
  localparam int MOD_TOP   = 14;
  localparam int R_W       = 34;

  localparam logic [0:0] REQ_ADD   = 1'b0;
  localparam logic [0:0] REQ_QUERY = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ONE  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXERR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE  = 2'd2;

  localparam logic [CFG_W-1:0] WINDOW_RST = 32'd1000000;
  localparam logic [CFG_W-1:0] MAXERR_RST = 32'd100000;

  typedef logic [NUM_CH-1:0][VAL_W-1:0] vals_t;

  typedef struct packed {
    logic              is_query;
    logic [TIME_W-1:0] t;
    vals_t             vals;
  } req_t;

  typedef struct packed {
    vals_t             vals;
    logic [TIME_W-1:0] t;
  } sample_t;

  typedef struct packed {
    logic [CFG_W-1:0]  window;
    logic [CFG_W-1:0]  max_err;
    logic [MASK_W-1:0] angle_mask;
  } cfg_t;

  localparam int SUM_W = CNT_W + 1;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/tsi_if.sv =====
// ---------------------------------------------------------------------------
// tsi_req_if / tsi_rsp_if
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface tsi_req_if import tsi_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [TIME_W-1:0]        timestamp;
  logic signed [VAL_W-1:0]  in_value_0;
  logic signed [VAL_W-1:0]  in_value_1;
  logic signed [VAL_W-1:0]  in_value_2;
  logic signed [VAL_W-1:0]  in_value_3;

  modport source (output valid, req_type, timestamp, in_value_0, in_value_1,
                  in_value_2, in_value_3, input ready);
  modport sink (input valid, req_type, timestamp, in_value_0, in_value_1,
                in_value_2, in_value_3, output ready);
endinterface

interface tsi_rsp_if import tsi_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [TIME_W-1:0]        out_time;
  logic signed [VAL_W-1:0]  out_value_0;
  logic signed [VAL_W-1:0]  out_value_1;
  logic signed [VAL_W-1:0]  out_value_2;
  logic signed [VAL_W-1:0]  out_value_3;

  modport source (output valid, status, out_time, out_value_0, out_value_1,
                  out_value_2, out_value_3, input ready);
  modport sink (input valid, status, out_time, out_value_0, out_value_1,
                out_value_2, out_value_3, output ready);
endinterface

// ===== hw/rtl/timestamped_sample_interpolator_unit.sv =====
// ---------------------------------------------------------------------------
// timestamped_sample_interpolator_unit
// Ring of 64 timestamped four-channel samples with query by interpolation.
// ---------------------------------------------------------------------------
// Words enter a two-deep queue and are executed one at a time by the back
// end, which owns the sample RAM with its one write and one read port. An
// add writes the sample, then reads the oldest held sample and evicts it
// while its age reaches the window. A query scans the held samples one RAM
// read a cycle, then either answers at once or runs the weight divider and
// then each channel in turn, with a two pi wrap for angle channels. A finished
// result waits in the output register while the next word is taken.
module timestamped_sample_interpolator_unit import tsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  tsi_req_if.sink              req,
  tsi_rsp_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg;
  logic q_valid;
  req_t q_word;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window     <= WINDOW_RST;
      cfg.max_err    <= MAXERR_RST;
      cfg.angle_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW: cfg.window     <= cfg_wdata;
        CFG_MAXERR: cfg.max_err    <= cfg_wdata;
        CFG_ANGLE:  cfg.angle_mask <= cfg_wdata[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tsi_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop)
  );

  tsi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .rsp     (rsp)
  );

endmodule

// ===== hw/rtl/tsi_ram.sv =====
// ---------------------------------------------------------------------------
// tsi_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tsi_front.sv =====
// ---------------------------------------------------------------------------
// tsi_front
// Accepts request words, tags them as add or query and queues two of them.
// ---------------------------------------------------------------------------
module tsi_front import tsi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tsi_req_if.sink   req,
  output logic      q_valid,
  output req_t      q_word,
  input  logic      q_pop
);

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign q_word    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].is_query <= (req.req_type == REQ_QUERY);
      slots[wr_ptr].t        <= req.timestamp;
      slots[wr_ptr].vals     <= {req.in_value_3, req.in_value_2,
                                 req.in_value_1, req.in_value_0};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hw/rtl/tsi_div.sv =====
// ---------------------------------------------------------------------------
// tsi_div
// Restoring divider for the 16-bit interpolation weight, one bit a cycle.
// ---------------------------------------------------------------------------
module tsi_div import tsi_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [31:0]    num,
  input  logic [32:0]    den,
  output logic           done,
  output logic [W_W-1:0] quo
);

  logic [33:0] rem;
  logic [33:0] dreg;
  logic [4:0]  cnt;
  logic        busy;
  logic [33:0] r2;
  logic        take;

  // The numerator is below the divisor, so the quotient of num<<16 has 16 bits.
  assign r2   = {rem[32:0], 1'b0};
  assign take = (r2 >= dreg);

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {2'b00, num};
      dreg <= {1'b0, den};
      cnt  <= 5'(W_W);
    end else if (busy) begin
      rem <= take ? (r2 - dreg) : r2;
      quo <= {quo[W_W-2:0], take};
      cnt <= cnt - 5'd1;
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/tsi_back.sv =====
// ---------------------------------------------------------------------------
// tsi_back
// Executes queued words: ring update with eviction, query scan, neighbour
// selection and per-channel interpolation into the output register.
// ---------------------------------------------------------------------------
module tsi_back import tsi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  req_t      q_word,
  output logic      q_pop,
  input  cfg_t      cfg,
  tsi_rsp_if.source rsp
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD    = 4'd1;
  localparam logic [3:0] S_EV_RD  = 4'd2;
  localparam logic [3:0] S_EV_CMP = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_PREP   = 4'd7;
  localparam logic [3:0] S_MOD    = 4'd8;
  localparam logic [3:0] S_WRAP   = 4'd9;
  localparam logic [3:0] S_MUL    = 4'd10;
  localparam logic [3:0] S_CHOUT  = 4'd11;
  localparam logic [3:0] S_RESULT = 4'd12;

  localparam int P_W = R_W + W_W + 1;
  localparam int S_W = 36;
  localparam int D_W = VAL_W + 1;
  localparam logic [MOD_W-1:0] MOD_BASE = MOD_W'(TWO_PI) << MOD_TOP;

  logic [3:0]        state;
  logic [CNT_W-1:0]  held;
  logic [IDX_W-1:0]  oldest;
  logic [TIME_W-1:0] cur_t;
  vals_t             cur_vals;
  logic [CNT_W-1:0]  k;
  logic              pend;
  logic              hit;
  logic              a_ok;
  logic              b_ok;
  logic [TIME_W-1:0] a_t;
  logic [TIME_W-1:0] b_t;
  vals_t             a_vals;
  vals_t             b_vals;
  logic [W_W-1:0]    w;
  logic [CH_W-1:0]   ch;
  logic [MOD_W-1:0]  mx;
  logic [3:0]        mk;
  logic signed [R_W-1:0] r;
  logic signed [P_W-1:0] prod;
  logic [1:0]        res_status;
  logic [TIME_W-1:0] res_time;
  vals_t             res_vals;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [TIME_W-1:0] out_time;
  vals_t             out_vals;

  logic              full;
  logic [IDX_W-1:0]  add_pos;
  logic              issue;
  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [$bits(sample_t)-1:0] ram_rdata;
  sample_t           rd_s;
  sample_t           wr_s;
  logic [TIME_W-1:0] ea;
  logic [TIME_W-1:0] eb;
  logic              a_use;
  logic              b_use;
  logic signed [63:0] age;
  logic signed [VAL_W-1:0] av;
  logic signed [VAL_W-1:0] bv;
  logic signed [D_W-1:0]   diff;
  logic [MOD_W-1:0]  mod_sub;
  logic signed [P_W-1:0] prod_sh;
  logic signed [S_W-1:0] sum;
  logic [VAL_W-1:0]  sat;
  logic              rsp_free;
  logic              div_start;
  logic              div_done;
  logic [W_W-1:0]    div_quo;

  always_comb begin
    q_pop     = (state == S_IDLE) && q_valid;
    full      = (held >= CNT_W'(DEPTH));
    add_pos   = full ? oldest : ring_add(oldest, held);
    ram_we    = (state == S_ADD);
    wr_s.t    = cur_t;
    wr_s.vals = cur_vals;
    issue     = (state == S_SCAN) && (k < held) && !hit;
    ram_re    = issue || ((state == S_EV_RD) && (held != '0));
    ram_raddr = (state == S_SCAN) ? ring_add(oldest, k) : oldest;
    rd_s      = sample_t'(ram_rdata);
    ea        = cur_t - a_t;
    eb        = b_t - cur_t;
    a_use     = a_ok && (ea <= TIME_W'(cfg.max_err));
    b_use     = b_ok && (eb <= TIME_W'(cfg.max_err));
    age       = $signed({1'b0, cur_t}) - $signed({1'b0, rd_s.t});
    div_start = (state == S_DECIDE) && !hit && a_use && b_use;
    av        = $signed(a_vals[ch]);
    bv        = $signed(b_vals[ch]);
    diff      = D_W'(bv) - D_W'(av);
    mod_sub   = MOD_W'(TWO_PI) << mk;
    prod_sh   = prod >>> W_W;
    sum       = S_W'(av) + S_W'(prod_sh);
    if (sum > S_W'(32'sh7FFFFFFF)) begin
      sat = 32'h7FFFFFFF;
    end else if (sum < -S_W'(33'sh080000000)) begin
      sat = 32'h80000000;
    end else begin
      sat = sum[VAL_W-1:0];
    end
    rsp_free  = !out_valid || rsp.ready;
  end

  tsi_ram #(
    .WIDTH($bits(sample_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (add_pos),
    .wdata (wr_s),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tsi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ea[31:0]),
    .den   (33'(ea) + 33'(eb)),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      oldest    <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      a_ok      <= 1'b0;
      b_ok      <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_RESULT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_t    <= q_word.t;
            cur_vals <= q_word.vals;
            k        <= '0;
            pend     <= 1'b0;
            hit      <= 1'b0;
            a_ok     <= 1'b0;
            b_ok     <= 1'b0;
            state    <= q_word.is_query ? S_SCAN : S_ADD;
          end
        end
        S_ADD: begin
          if (full) oldest <= ring_add(oldest, CNT_W'(1));
          else held <= held + CNT_W'(1);
          state <= S_EV_RD;
        end
        S_EV_RD: begin
          state <= (held == '0) ? S_IDLE : S_EV_CMP;
        end
        S_EV_CMP: begin
          if (age >= $signed({32'd0, cfg.window})) begin
            oldest <= ring_add(oldest, CNT_W'(1));
            held   <= held - CNT_W'(1);
            state  <= S_EV_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          pend <= issue;
          if (issue) k <= k + CNT_W'(1);
          if (pend && !hit) begin
            if (rd_s.t == cur_t) begin
              hit    <= 1'b1;
              a_vals <= rd_s.vals;
            end else begin
              // Strictly nearer only, so ties keep the first one scanned.
              if (rd_s.t < cur_t && (!a_ok || rd_s.t > a_t)) begin
                a_ok   <= 1'b1;
                a_t    <= rd_s.t;
                a_vals <= rd_s.vals;
              end
              if (rd_s.t > cur_t && (!b_ok || rd_s.t < b_t)) begin
                b_ok   <= 1'b1;
                b_t    <= rd_s.t;
                b_vals <= rd_s.vals;
              end
            end
          end
          if (!pend && !issue) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (hit) begin
            res_status <= ST_OK;
            res_time   <= cur_t;
            res_vals   <= a_vals;
            state      <= S_RESULT;
          end else if (a_use && b_use) begin
            state <= S_DIV;
          end else if (a_use) begin
            res_status <= ST_ONE;
            res_time   <= a_t;
            res_vals   <= a_vals;
            state      <= S_RESULT;
          end else if (b_use) begin
            res_status <= ST_ONE;
            res_time   <= b_t;
            res_vals   <= b_vals;
            state      <= S_RESULT;
          end else begin
            res_status <= ST_NONE;
            res_time   <= '0;
            res_vals   <= '0;
            state      <= S_RESULT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            w     <= div_quo;
            ch    <= '0;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (cfg.angle_mask[ch]) begin
            // Offset by a multiple of two pi so the remainder search stays positive.
            mx    <= MOD_W'(diff) + MOD_BASE;
            mk    <= 4'(MOD_TOP);
            state <= S_MOD;
          end else begin
            r     <= R_W'(diff);
            state <= S_MUL;
          end
        end
        S_MOD: begin
          if (mx >= mod_sub) mx <= mx - mod_sub;
          if (mk == 4'd0) state <= S_WRAP;
          else mk <= mk - 4'd1;
        end
        S_WRAP: begin
          if (mx > MOD_W'(PI_FLOOR)) r <= R_W'(mx) - R_W'(TWO_PI);
          else r <= R_W'(mx);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= r * $signed({1'b0, w});
          state <= S_CHOUT;
        end
        S_CHOUT: begin
          res_vals[ch] <= sat;
          if (ch == CH_W'(NUM_CH - 1)) begin
            res_status <= ST_OK;
            res_time   <= cur_t;
            state      <= S_RESULT;
          end else begin
            ch    <= ch + CH_W'(1);
            state <= S_PREP;
          end
        end
        S_RESULT: begin
          if (rsp_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && rsp_free) begin
      out_status <= res_status;
      out_time   <= res_time;
      out_vals   <= res_vals;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.out_time    = out_time;
  assign rsp.out_value_0 = out_vals[0];
  assign rsp.out_value_1 = out_vals[1];
  assign rsp.out_value_2 = out_vals[2];
  assign rsp.out_value_3 = out_vals[3];

endmodule
